// ===== hw/rtl/can_rff_pkg.sv =====
package can_rff_pkg;

  localparam int CHANNELS       = 2;
  localparam int CH_W           = 1;
  localparam int DEF_RING_DEPTH = 16;

  localparam int OP_W     = 2;
  localparam int ID_W     = 29;
  localparam int DATA_W   = 64;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 32;
  localparam int FILL_W   = 5;
  localparam int WORD_W   = DATA_W + TIME_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CH0_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CH1_ID = 1'd1;

  localparam logic [ID_W-1:0] RESET_CH0_ID = 29'h2901;
  localparam logic [ID_W-1:0] RESET_CH1_ID = 29'h2902;

  typedef struct packed {
    logic              frame_accepted;
    logic [CH_W-1:0]   channel_hit;
    logic              overwrote_oldest;
    logic              pop_valid;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  received_total;
    logic [CNT_W-1:0]  processed_total;
    logic [TIME_W-1:0] last_arrival;
  } res_t;

endpackage

// ===== hw/rtl/can_rx_filter_fifo.sv =====
// Channel  | Handshake            | Word
// input    | start, busy          | in_operation, in_frame_id, in_frame_data,
//          |                      | in_arrival_time, in_channel_select
// result   | out_valid            | out_* (one word per accepted item)
// config   | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while busy is low; its result strobes out_valid in the following cycle.
// A pop reads the ring memory at the accepting edge; the memory's output
// register supplies out_payload and out_payload_time in the result cycle.
// busy is set while rst_n is low and is cleared on any edge with rst_n high; no clearing pass.
// The receiver cannot stall: each result word is shown for one cycle only.
module can_rx_filter_fifo #(
  parameter int RING_DEPTH = can_rff_pkg::DEF_RING_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [can_rff_pkg::OP_W-1:0]      in_operation,
  input  logic [can_rff_pkg::ID_W-1:0]      in_frame_id,
  input  logic [can_rff_pkg::DATA_W-1:0]    in_frame_data,
  input  logic [can_rff_pkg::TIME_W-1:0]    in_arrival_time,
  input  logic [can_rff_pkg::CH_W-1:0]      in_channel_select,
  input  logic                              cfg_we,
  input  logic [can_rff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [can_rff_pkg::ID_W-1:0]      cfg_data,
  output logic                              out_valid,
  output logic                              out_frame_accepted,
  output logic [can_rff_pkg::CH_W-1:0]      out_channel_hit,
  output logic                              out_overwrote_oldest,
  output logic                              out_pop_valid,
  output logic [can_rff_pkg::DATA_W-1:0]    out_payload,
  output logic [can_rff_pkg::TIME_W-1:0]    out_payload_time,
  output logic [can_rff_pkg::FILL_W-1:0]    out_fill_level,
  output logic [can_rff_pkg::CNT_W-1:0]     out_received_total,
  output logic [can_rff_pkg::CNT_W-1:0]     out_processed_total,
  output logic [can_rff_pkg::TIME_W-1:0]    out_last_arrival
);
  import can_rff_pkg::*;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int ADDR_W = CH_W + PTR_W;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  res_t              res;

  can_rff_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W),
    .OCC_W      ($clog2(RING_DEPTH + 1)),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_frame_id       (in_frame_id),
    .in_frame_data     (in_frame_data),
    .in_arrival_time   (in_arrival_time),
    .in_channel_select (in_channel_select),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ram_we            (ram_we),
    .ram_re            (ram_re),
    .ram_addr          (ram_addr),
    .ram_wdata         (ram_wdata),
    .res_valid         (out_valid),
    .res               (res)
  );

  can_rff_ram #(
    .ADDR_W (ADDR_W),
    .WORD_W (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_frame_accepted   = res.frame_accepted;
  assign out_channel_hit      = res.channel_hit;
  assign out_overwrote_oldest = res.overwrote_oldest;
  assign out_pop_valid        = res.pop_valid;
  assign out_payload          = res.pop_valid ? ram_rdata[WORD_W-1 -: DATA_W] : '0;
  assign out_payload_time     = res.pop_valid ? ram_rdata[TIME_W-1:0] : '0;
  assign out_fill_level       = res.fill_level;
  assign out_received_total   = res.received_total;
  assign out_processed_total  = res.processed_total;
  assign out_last_arrival     = res.last_arrival;

endmodule

// ===== hw/rtl/can_rff_ram.sv =====
module can_rff_ram #(
  parameter int ADDR_W = can_rff_pkg::CH_W + $clog2(can_rff_pkg::DEF_RING_DEPTH),
  parameter int WORD_W = can_rff_pkg::WORD_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem_r [2**ADDR_W];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/can_rff_ctrl.sv =====
module can_rff_ctrl #(
  parameter int RING_DEPTH = can_rff_pkg::DEF_RING_DEPTH,
  parameter int PTR_W      = $clog2(RING_DEPTH),
  parameter int OCC_W      = $clog2(RING_DEPTH + 1),
  parameter int ADDR_W     = can_rff_pkg::CH_W + PTR_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [can_rff_pkg::OP_W-1:0]        in_operation,
  input  logic [can_rff_pkg::ID_W-1:0]        in_frame_id,
  input  logic [can_rff_pkg::DATA_W-1:0]      in_frame_data,
  input  logic [can_rff_pkg::TIME_W-1:0]      in_arrival_time,
  input  logic [can_rff_pkg::CH_W-1:0]        in_channel_select,
  input  logic                                cfg_we,
  input  logic [can_rff_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [can_rff_pkg::ID_W-1:0]        cfg_data,
  output logic                                ram_we,
  output logic                                ram_re,
  output logic [ADDR_W-1:0]                   ram_addr,
  output logic [can_rff_pkg::WORD_W-1:0]      ram_wdata,
  output logic                                res_valid,
  output can_rff_pkg::res_t                   res
);
  import can_rff_pkg::*;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [ID_W-1:0]   id0_r, id1_r;
  logic              busy_r;
  logic              res_valid_r;
  res_t              res_r, res_nxt;

  logic [PTR_W-1:0]  wp_r  [CHANNELS];
  logic [PTR_W-1:0]  wp_nxt[CHANNELS];
  logic [PTR_W-1:0]  rp_r  [CHANNELS];
  logic [PTR_W-1:0]  rp_nxt[CHANNELS];
  logic [OCC_W-1:0]  occ_r  [CHANNELS];
  logic [OCC_W-1:0]  occ_nxt[CHANNELS];
  logic [CNT_W-1:0]  rcv_r  [CHANNELS];
  logic [CNT_W-1:0]  rcv_nxt[CHANNELS];
  logic [CNT_W-1:0]  prc_r  [CHANNELS];
  logic [CNT_W-1:0]  prc_nxt[CHANNELS];
  logic [TIME_W-1:0] lt_r  [CHANNELS];
  logic [TIME_W-1:0] lt_nxt[CHANNELS];

  logic              acc;
  logic              match0, match1;
  logic [CH_W-1:0]   ch;

  assign acc    = start && !busy_r;
  assign match0 = (in_frame_id == id0_r);
  assign match1 = (in_frame_id == id1_r);
  assign ch     = (in_operation == OP_FRAME) ? (match0 ? '0 : CH_W'(1)) : in_channel_select;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    occ_nxt   = occ_r;
    rcv_nxt   = rcv_r;
    prc_nxt   = prc_r;
    lt_nxt    = lt_r;
    res_nxt   = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = {ch, wp_r[ch]};
    ram_wdata = {in_frame_data, in_arrival_time};
    if (acc) begin
      unique case (in_operation)
        OP_FRAME: begin
          if (match0 || match1) begin
            ram_we      = 1'b1;
            wp_nxt[ch]  = ring_next(wp_r[ch]);
            if (occ_r[ch] >= OCC_W'(RING_DEPTH)) begin
              rp_nxt[ch] = ring_next(rp_r[ch]);
              res_nxt.overwrote_oldest = 1'b1;
            end else begin
              occ_nxt[ch] = occ_r[ch] + OCC_W'(1);
            end
            rcv_nxt[ch] = rcv_r[ch] + CNT_W'(1);
            lt_nxt[ch]  = in_arrival_time;
            res_nxt.frame_accepted  = 1'b1;
            res_nxt.channel_hit     = ch;
            res_nxt.fill_level      = FILL_W'(occ_nxt[ch]);
            res_nxt.received_total  = rcv_nxt[ch];
            res_nxt.processed_total = prc_r[ch];
            res_nxt.last_arrival    = in_arrival_time;
          end
        end
        OP_POP: begin
          if (occ_r[ch] != '0) begin
            ram_re      = 1'b1;
            ram_addr    = {ch, rp_r[ch]};
            rp_nxt[ch]  = ring_next(rp_r[ch]);
            occ_nxt[ch] = occ_r[ch] - OCC_W'(1);
            prc_nxt[ch] = prc_r[ch] + CNT_W'(1);
            res_nxt.pop_valid = 1'b1;
          end
          res_nxt.channel_hit     = ch;
          res_nxt.fill_level      = FILL_W'(occ_nxt[ch]);
          res_nxt.received_total  = rcv_r[ch];
          res_nxt.processed_total = prc_nxt[ch];
          res_nxt.last_arrival    = lt_r[ch];
        end
        OP_CLEAR: begin
          res_nxt.channel_hit     = ch;
          res_nxt.fill_level      = FILL_W'(occ_r[ch]);
          res_nxt.received_total  = rcv_r[ch];
          res_nxt.processed_total = prc_r[ch];
          res_nxt.last_arrival    = lt_r[ch];
          rcv_nxt[ch] = '0;
          prc_nxt[ch] = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      res_valid_r <= 1'b0;
      id0_r       <= RESET_CH0_ID;
      id1_r       <= RESET_CH1_ID;
      wp_r        <= '{default: '0};
      rp_r        <= '{default: '0};
      occ_r       <= '{default: '0};
      rcv_r       <= '{default: '0};
      prc_r       <= '{default: '0};
      lt_r        <= '{default: '0};
    end else begin
      busy_r      <= 1'b0;
      res_valid_r <= acc;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CH0_ID: id0_r <= cfg_data;
          CFG_CH1_ID: id1_r <= cfg_data;
          default: begin
          end
        endcase
      end
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      occ_r <= occ_nxt;
      rcv_r <= rcv_nxt;
      prc_r <= prc_nxt;
      lt_r  <= lt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  assign busy      = busy_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/can_rff_checker.sv =====
module can_rff_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [can_rff_pkg::OP_W-1:0] in_operation,
  input logic                         out_valid,
  input logic                         out_frame_accepted,
  input logic                         out_overwrote_oldest,
  input logic                         out_pop_valid
);
  import can_rff_pkg::*;

  a_one_word_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted item gave no result word");

  a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result word without accepted item");

  a_accept_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_accepted) |->
      ($past(in_operation) == OP_FRAME && !out_pop_valid))
    else $error("frame acceptance on a non-frame item");

  a_pop_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pop_valid) |-> ($past(in_operation) == OP_POP))
    else $error("pop data on a non-pop item");

  a_overwrite_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overwrote_oldest) |-> out_frame_accepted)
    else $error("overwrite flagged without stored frame");

endmodule

bind can_rx_filter_fifo can_rff_checker u_can_rff_checker (.*);

// ===== tb/sv/can_rx_filter_fifo_checker.sv =====
`timescale 1ns / 100ps

module can_rx_filter_fifo_checker
  import can_rff_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ID_W-1:0]    in_frame_id,
  input  logic [DATA_W-1:0]  in_frame_data,
  input  logic [TIME_W-1:0]  in_arrival_time,
  input  logic [CH_W-1:0]    in_channel_select,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]    cfg_data,
  input  logic               out_valid,
  input  logic               out_frame_accepted,
  input  logic [CH_W-1:0]    out_channel_hit,
  input  logic               out_overwrote_oldest,
  input  logic               out_pop_valid,
  input  logic [DATA_W-1:0]  out_payload,
  input  logic [TIME_W-1:0]  out_payload_time,
  input  logic [FILL_W-1:0]  out_fill_level,
  input  logic [CNT_W-1:0]   out_received_total,
  input  logic [CNT_W-1:0]   out_processed_total,
  input  logic [TIME_W-1:0]  out_last_arrival,
  output int                 words_open,
  output int                 fail_count
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  typedef logic [PTR_W-1:0] ring_ptr_t;

  typedef struct packed {
    logic              frame_accepted;
    logic [CH_W-1:0]   channel_hit;
    logic              overwrote_oldest;
    logic              pop_valid;
    logic [DATA_W-1:0] payload;
    logic [TIME_W-1:0] payload_time;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  received_total;
    logic [CNT_W-1:0]  processed_total;
    logic [TIME_W-1:0] last_arrival;
  } rx_word_t;

  logic [DATA_W-1:0] payload_mem [CHANNELS][RING_DEPTH];
  logic [TIME_W-1:0] stamp_mem   [CHANNELS][RING_DEPTH];
  ring_ptr_t         wr_ptr      [CHANNELS];
  ring_ptr_t         rd_ptr      [CHANNELS];
  logic [FILL_W-1:0] fill        [CHANNELS];
  logic [CNT_W-1:0]  rx_cnt      [CHANNELS];
  logic [CNT_W-1:0]  done_cnt    [CHANNELS];
  logic [TIME_W-1:0] last_stamp  [CHANNELS];
  logic [ID_W-1:0]   match_id    [CHANNELS];

  rx_word_t due_words [$];
  int       n_fail = 0;

  function automatic ring_ptr_t ring_step(ring_ptr_t p);
    return (p == ring_ptr_t'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic rx_word_t channel_view(rx_word_t w, logic [CH_W-1:0] ch);
    w.channel_hit     = ch;
    w.fill_level      = fill[ch];
    w.received_total  = rx_cnt[ch];
    w.processed_total = done_cnt[ch];
    w.last_arrival    = last_stamp[ch];
    return w;
  endfunction

  function automatic rx_word_t filter_and_store(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                                logic [DATA_W-1:0] data,
                                                logic [TIME_W-1:0] stamp,
                                                logic [CH_W-1:0] sel);
    rx_word_t        w;
    logic [CH_W-1:0] ch;
    logic            hit;
    w   = '0;
    hit = 1'b1;
    ch  = '0;
    case (op)
      OP_FRAME: begin
        if (id == match_id[0]) ch = 1'b0;
        else if (id == match_id[1]) ch = 1'b1;
        else hit = 1'b0;
        if (hit) begin
          payload_mem[ch][wr_ptr[ch]] = data;
          stamp_mem[ch][wr_ptr[ch]]   = stamp;
          wr_ptr[ch] = ring_step(wr_ptr[ch]);
          if (fill[ch] >= RING_DEPTH) begin
            rd_ptr[ch] = ring_step(rd_ptr[ch]);
            w.overwrote_oldest = 1'b1;
          end else begin
            fill[ch] = fill[ch] + 1'b1;
          end
          rx_cnt[ch]     = rx_cnt[ch] + 1'b1;
          last_stamp[ch] = stamp;
          w.frame_accepted = 1'b1;
          w = channel_view(w, ch);
        end
      end
      OP_POP: begin
        ch = sel;
        if (fill[ch] != 0) begin
          w.pop_valid    = 1'b1;
          w.payload      = payload_mem[ch][rd_ptr[ch]];
          w.payload_time = stamp_mem[ch][rd_ptr[ch]];
          rd_ptr[ch]     = ring_step(rd_ptr[ch]);
          fill[ch]       = fill[ch] - 1'b1;
          done_cnt[ch]   = done_cnt[ch] + 1'b1;
        end
        w = channel_view(w, ch);
      end
      OP_CLEAR: begin
        ch = sel;
        w = channel_view(w, ch);
        rx_cnt[ch]   = '0;
        done_cnt[ch] = '0;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic compare_field(string tag, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, tag, want, got);
    end
  endtask

  always @(posedge clk) begin
    rx_word_t want;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_ptr[c]     = '0;
        rd_ptr[c]     = '0;
        fill[c]       = '0;
        rx_cnt[c]     = '0;
        done_cnt[c]   = '0;
        last_stamp[c] = '0;
      end
      match_id[0] = RESET_CH0_ID;
      match_id[1] = RESET_CH1_ID;
      due_words.delete();
    end else begin
      if (out_valid) begin
        if (due_words.size() == 0) begin
          n_fail++;
          $display("%0t: result word with nothing expected, expected none, got %h",
                   $realtime, out_fill_level);
        end else begin
          want = due_words.pop_front();
          compare_field("frame_accepted", want.frame_accepted, out_frame_accepted);
          compare_field("channel_hit", want.channel_hit, out_channel_hit);
          compare_field("overwrote_oldest", want.overwrote_oldest, out_overwrote_oldest);
          compare_field("pop_valid", want.pop_valid, out_pop_valid);
          compare_field("payload", want.payload, out_payload);
          compare_field("payload_time", want.payload_time, out_payload_time);
          compare_field("fill_level", want.fill_level, out_fill_level);
          compare_field("received_total", want.received_total, out_received_total);
          compare_field("processed_total", want.processed_total, out_processed_total);
          compare_field("last_arrival", want.last_arrival, out_last_arrival);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CH0_ID: match_id[0] = cfg_data;
          CFG_CH1_ID: match_id[1] = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        due_words.push_back(filter_and_store(in_operation, in_frame_id, in_frame_data,
                                             in_arrival_time, in_channel_select));
    end
    words_open <= due_words.size();
    fail_count <= n_fail;
  end

endmodule

// ===== tb/sv/can_rx_filter_fifo_test.sv =====
`timescale 1ns / 100ps

module can_rx_filter_fifo_test;
  import can_rff_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [ID_W-1:0] ID_ZERO     = '0;
  localparam logic [ID_W-1:0] ID_ONES     = '1;
  localparam int              RAND_PHASES = 6;
  localparam int              PHASE_WORDS = 140;
  localparam int              SEG_WORDS   = 20;
  localparam int              STALL_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_operation = OP_FRAME;
  logic [ID_W-1:0]      in_frame_id = '0;
  logic [DATA_W-1:0]    in_frame_data = '0;
  logic [TIME_W-1:0]    in_arrival_time = '0;
  logic [CH_W-1:0]      in_channel_select = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CH0_ID;
  logic [ID_W-1:0]      cfg_data = '0;
  logic                 out_valid;
  logic                 out_frame_accepted;
  logic [CH_W-1:0]      out_channel_hit;
  logic                 out_overwrote_oldest;
  logic                 out_pop_valid;
  logic [DATA_W-1:0]    out_payload;
  logic [TIME_W-1:0]    out_payload_time;
  logic [FILL_W-1:0]    out_fill_level;
  logic [CNT_W-1:0]     out_received_total;
  logic [CNT_W-1:0]     out_processed_total;
  logic [TIME_W-1:0]    out_last_arrival;
  int                   words_open;
  int                   fail_count;

  logic [ID_W-1:0] live_id [CHANNELS];
  logic            gaps_on = 1'b1;
  logic            seg_gaps = 1'b0;
  int              n_frames = 0;
  int              n_pops = 0;
  int              n_clears = 0;
  int              n_other = 0;
  int              n_settings = 1;
  int              stall_cycles = 0;

  always #5 clk = ~clk;

  can_rx_filter_fifo i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_frame_id         (in_frame_id),
    .in_frame_data       (in_frame_data),
    .in_arrival_time     (in_arrival_time),
    .in_channel_select   (in_channel_select),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_frame_accepted  (out_frame_accepted),
    .out_channel_hit     (out_channel_hit),
    .out_overwrote_oldest(out_overwrote_oldest),
    .out_pop_valid       (out_pop_valid),
    .out_payload         (out_payload),
    .out_payload_time    (out_payload_time),
    .out_fill_level      (out_fill_level),
    .out_received_total  (out_received_total),
    .out_processed_total (out_processed_total),
    .out_last_arrival    (out_last_arrival)
  );

  can_rx_filter_fifo_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_frame_id         (in_frame_id),
    .in_frame_data       (in_frame_data),
    .in_arrival_time     (in_arrival_time),
    .in_channel_select   (in_channel_select),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_frame_accepted  (out_frame_accepted),
    .out_channel_hit     (out_channel_hit),
    .out_overwrote_oldest(out_overwrote_oldest),
    .out_pop_valid       (out_pop_valid),
    .out_payload         (out_payload),
    .out_payload_time    (out_payload_time),
    .out_fill_level      (out_fill_level),
    .out_received_total  (out_received_total),
    .out_processed_total (out_processed_total),
    .out_last_arrival    (out_last_arrival),
    .words_open          (words_open),
    .fail_count          (fail_count)
  );

  // no progress on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL can_rx_filter_fifo");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [DATA_W-1:0] data, logic [TIME_W-1:0] stamp,
                           logic [CH_W-1:0] sel);
    start             <= 1'b1;
    in_operation      <= op;
    in_frame_id       <= id;
    in_frame_data     <= data;
    in_arrival_time   <= stamp;
    in_channel_select <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      OP_FRAME: n_frames++;
      OP_POP:   n_pops++;
      OP_CLEAR: n_clears++;
      default:  n_other++;
    endcase
    if (gaps_on && seg_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (words_open != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_ids(logic [ID_W-1:0] id0, logic [ID_W-1:0] id1);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CH0_ID;
    cfg_data  <= id0;
    @(posedge clk);
    cfg_index <= CFG_CH1_ID;
    cfg_data  <= id1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    live_id[0] = id0;
    live_id[1] = id1;
    n_settings++;
  endtask

  task automatic random_word(int frame_pct, logic flood, logic [CH_W-1:0] flood_ch);
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [CH_W-1:0] ch;
    int              r;
    ch = flood ? flood_ch : CH_W'($urandom_range(0, 1));
    id = ID_W'($urandom);
    r  = $urandom_range(0, 99);
    if (r < frame_pct) begin
      op = OP_FRAME;
      if (flood || $urandom_range(0, 99) < 85) id = live_id[ch];
    end else begin
      r = $urandom_range(0, 99);
      if (r < 88) op = OP_POP;
      else if (r < 97) op = OP_CLEAR;
      else op = OP_RESERVED;
    end
    send_word(op, id, {$urandom, $urandom}, $urandom,
              (op == OP_FRAME) ? CH_W'($urandom_range(0, 1)) : ch);
  endtask

  initial begin
    int              mode;
    logic [ID_W-1:0] pick;
    live_id[0] = RESET_CH0_ID;
    live_id[1] = RESET_CH1_ID;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty pops, idle clear, reserved code, extremes of the payload
    send_word(OP_POP, ID_ZERO, '0, '0, 1'b0);
    send_word(OP_POP, ID_ZERO, '0, '0, 1'b1);
    send_word(OP_CLEAR, ID_ZERO, '0, '0, 1'b0);
    send_word(OP_RESERVED, ID_ONES, '1, '1, 1'b1);
    send_word(OP_FRAME, RESET_CH0_ID, '1, '1, 1'b1);
    send_word(OP_FRAME, RESET_CH1_ID, '0, '0, 1'b0);
    send_word(OP_FRAME, ID_ONES, '1, '1, 1'b0);
    send_word(OP_FRAME, ID_ZERO, '1, '1, 1'b1);
    send_word(OP_POP, ID_ONES, '1, '1, 1'b0);
    send_word(OP_POP, ID_ZERO, '0, '0, 1'b1);
    send_word(OP_POP, ID_ZERO, '0, '0, 1'b1);
    send_word(OP_CLEAR, ID_ZERO, '0, '0, 1'b0);
    settle();

    // equal identifiers: channel zero takes the frame
    set_ids(ID_ZERO, ID_ZERO);
    send_word(OP_FRAME, ID_ZERO, 64'h0123_4567_89AB_CDEF, 32'h8000_0001, 1'b1);
    send_word(OP_FRAME, ID_ONES, '1, '1, 1'b1);
    send_word(OP_CLEAR, ID_ZERO, '0, '0, 1'b1);
    send_word(OP_POP, ID_ZERO, '0, '0, 1'b0);
    settle();
    set_ids(ID_ONES, ID_ZERO);
    send_word(OP_FRAME, ID_ONES, '0, '1, 1'b0);
    send_word(OP_FRAME, ID_ZERO, '1, '0, 1'b0);
    send_word(OP_CLEAR, ID_ZERO, '0, '0, 1'b1);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = ID_W'($urandom);
      case (ph)
        0: set_ids(ID_ZERO, ID_ONES);
        1: set_ids(29'h1555_5555, 29'h0AAA_AAAA);
        2: set_ids(29'h0AAA_AAAA, 29'h1555_5555);
        5: set_ids(pick, pick);
        default: set_ids(pick, ID_W'($urandom));
      endcase
      gaps_on = (ph != RAND_PHASES - 1);
      for (int s = 0; s < PHASE_WORDS / SEG_WORDS; s++) begin
        mode     = $urandom_range(0, 3);
        seg_gaps = ($urandom_range(0, 2) != 0);
        for (int k = 0; k < SEG_WORDS; k++) begin
          case (mode)
            0: random_word(50, 1'b0, 1'b0);
            1: random_word(80, 1'b0, 1'b0);
            2: random_word(20, 1'b0, 1'b0);
            default: random_word(100, 1'b1, CH_W'(s));
          endcase
        end
      end
      settle();
    end

    repeat (4) @(posedge clk);
    $display("Covered %0d frames, %0d pops, %0d clears and %0d reserved words",
             n_frames, n_pops, n_clears, n_other);
    $display("over %0d identifier settings, ring overflow floods and empty pops included",
             n_settings);
    if (fail_count == 0 && words_open == 0) begin
      $display("PASS can_rx_filter_fifo");
    end else begin
      $display("FAIL can_rx_filter_fifo");
    end
    $finish;
  end

endmodule
